>>> hw/rtl/swt4n_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// swt4n_pkg: shared types and constants of the skin weight normalizer
// Field widths, request/result structs, command and register codes, and the
// sequencer state type.
// ----------------------------------------------------------------------------
package swt4n_pkg;

    // Field widths
    localparam int VERTEX_W = 12;
    localparam int BONE_W   = 7;
    localparam int WEIGHT_W = 17;
    localparam int COUNT_W  = 13;
    localparam int DATA_W   = 32;
    localparam int PADDR_W  = 3;

    // Q1.16 one
    localparam int               WEIGHT_ONE = 65536;
    localparam logic [WEIGHT_W-1:0] ONE_Q16 = 17'h10000;

    // Number of slots reported in a result
    localparam int OUT_SLOTS = 4;
    localparam int OUT_IW    = 2;

    // Parameter defaults
    localparam int DEF_MAX_VERTICES = 4096;
    localparam int DEF_SLOTS        = 4;
    localparam int DEF_MAX_BONES    = 128;

    // Command codes
    localparam logic CMD_ADD  = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // Register index (paddr[PADDR_W-1:2])
    localparam logic REG_VERTEX_COUNT = 1'b0;

    typedef struct packed {
        logic                command;
        logic [VERTEX_W-1:0] vertex_id;
        logic [BONE_W-1:0]   bone_index;
        logic [WEIGHT_W-1:0] weight_in;
    } in_req_t;

    typedef struct packed {
        logic [VERTEX_W-1:0] vertex_out;
        logic [BONE_W-1:0]   bone_a;
        logic [BONE_W-1:0]   bone_b;
        logic [BONE_W-1:0]   bone_c;
        logic [BONE_W-1:0]   bone_d;
        logic [WEIGHT_W-1:0] share_a;
        logic [WEIGHT_W-1:0] share_b;
        logic [WEIGHT_W-1:0] share_c;
        logic [WEIGHT_W-1:0] share_d;
    } result_t;

    // One influence slot of a store entry
    typedef struct packed {
        logic [BONE_W-1:0]   bone;
        logic [WEIGHT_W-1:0] weight;
    } slot_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ADD,
        ST_SUM,
        ST_DIV,
        ST_OUT
    } state_t;

endpackage
`default_nettype wire

>>> hw/rtl/skin_weight_top4_normalizer_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// skin_weight_top4_normalizer_unit: top-4 bone influence store and normalizer
// Keeps SLOTS (bone, weight) slots per vertex; add requests replace the first
// weakest slot, read requests report normalized shares and clear the entry.
// ----------------------------------------------------------------------------
// After reset the block sweeps the influence store to zero, one entry per
// cycle, with busy high; vertex_count may be written over APB meanwhile. A
// request is taken when start is high and busy is low. An add request reads
// the store entry when it is taken and writes the updated entry back when
// the new weight beats the weakest slot; an add that is dropped (vertex at
// or beyond vertex_count, or bone out of range) leaves the block idle. A read
// request builds the slot sum one slot per cycle, then each reported share
// goes through one shared bit-serial divider that is started, produces 17
// quotient bits, one per cycle, and then signals done. A read of an entry
// whose weights are all zero skips the divider.
// The result appears on result for exactly one cycle with result_valid high,
// in the first cycle that busy is low again; there is no backpressure, so
// the receiver must take it then.
// ----------------------------------------------------------------------------
module skin_weight_top4_normalizer_unit #(
    parameter int MAX_VERTICES = swt4n_pkg::DEF_MAX_VERTICES,
    parameter int SLOTS        = swt4n_pkg::DEF_SLOTS,
    parameter int MAX_BONES    = swt4n_pkg::DEF_MAX_BONES
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    // APB configuration port
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [swt4n_pkg::PADDR_W-1:0] paddr,
    input  wire logic [swt4n_pkg::DATA_W-1:0] pwdata,
    output logic [swt4n_pkg::DATA_W-1:0]      prdata,
    output logic                              pready,
    // Request channel
    input  wire logic                         start,
    input  wire swt4n_pkg::in_req_t           request,
    output logic                              busy,
    // Result channel
    output logic                              result_valid,
    output swt4n_pkg::result_t                result
);
    import swt4n_pkg::*;

    localparam int AW     = $clog2(MAX_VERTICES);
    localparam int SIW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int SUM_W  = $clog2(SLOTS * WEIGHT_ONE + 1);
    localparam int NO     = (SLOTS < OUT_SLOTS) ? SLOTS : OUT_SLOTS;

    // Influence store
    slot_t [SLOTS-1:0]   store_mem [MAX_VERTICES];
    slot_t [SLOTS-1:0]   rd_data_reg;
    logic                mem_wr_en;
    logic [AW-1:0]       mem_wr_addr;
    slot_t [SLOTS-1:0]   mem_wr_data;

    // Sequencer and control
    state_t              state_reg;
    state_t              state_next;
    logic [AW-1:0]       clr_addr_reg;
    logic [SIW-1:0]      slot_idx_reg;
    logic [OUT_IW-1:0]   out_idx_reg;
    logic                div_pend_reg;
    logic                result_valid_reg;
    logic [COUNT_W-1:0]  vertex_count_reg;
    logic                accept;
    logic                cfg_write;

    // Request payload held while working
    logic [VERTEX_W-1:0] vertex_reg;
    logic [AW-1:0]       addr_reg;
    logic [BONE_W-1:0]   bone_reg;
    logic [WEIGHT_W-1:0] weight_reg;
    logic                beyond_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [SUM_W-1:0]    sum_next;
    logic [WEIGHT_W-1:0] share_reg [OUT_SLOTS];
    result_t             result_reg;

    // Request decode
    logic [WEIGHT_W-1:0] weight_sat;
    logic                beyond_in;
    logic                add_ok;
    logic                sum_last;
    logic                out_last;

    // Add path
    logic [SIW-1:0]      weakest;
    logic                add_hit;
    slot_t [SLOTS-1:0]   add_entry;

    // Reported slot views
    logic [WEIGHT_W-1:0] out_weight [OUT_SLOTS];
    logic [BONE_W-1:0]   out_bone   [OUT_SLOTS];
    logic [BONE_W-1:0]   rep_bone   [OUT_SLOTS];
    logic [WEIGHT_W-1:0] rep_share  [OUT_SLOTS];

    // Shared divider
    logic                div_start;
    logic                div_done;
    logic [WEIGHT_W-1:0] div_quot;

    swt4n_div #(
        .DEN_W (SUM_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (out_weight[out_idx_reg]),
        .den   (sum_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    always_comb
    begin
        if (paddr[PADDR_W-1:2] == REG_VERTEX_COUNT)
        begin
            prdata = DATA_W'(vertex_count_reg);
        end
        else
        begin
            prdata = '0;
        end
    end

    // ------------------------------------------------------------------
    // Request decode
    // ------------------------------------------------------------------
    always_comb
    begin
        weight_sat = (request.weight_in > ONE_Q16) ? ONE_Q16 : request.weight_in;
        beyond_in  = 32'(request.vertex_id) >= 32'(MAX_VERTICES);
        add_ok     = (COUNT_W'(request.vertex_id) < vertex_count_reg) && !beyond_in
                     && (32'(request.bone_index) < 32'(MAX_BONES));
        sum_last   = slot_idx_reg == SIW'(SLOTS - 1);
        out_last   = out_idx_reg == OUT_IW'(NO - 1);
        sum_next   = sum_reg + SUM_W'(rd_data_reg[slot_idx_reg].weight);
    end

    assign accept = start && !busy;

    // ------------------------------------------------------------------
    // Add: pick the first weakest slot and replace it on a larger weight
    // ------------------------------------------------------------------
    always_comb
    begin
        weakest = '0;
        for (int s = 1; s < SLOTS; s++)
        begin
            if (rd_data_reg[s].weight < rd_data_reg[weakest].weight)
            begin
                weakest = SIW'(s);
            end
        end
        add_hit                   = weight_reg > rd_data_reg[weakest].weight;
        add_entry                 = rd_data_reg;
        add_entry[weakest].bone   = bone_reg;
        add_entry[weakest].weight = weight_reg;
    end

    // Map store slots onto the four reported slots; missing slots read zero
    always_comb
    begin
        for (int s = 0; s < OUT_SLOTS; s++)
        begin
            if (s < SLOTS)
            begin
                out_weight[s] = rd_data_reg[s].weight;
                out_bone[s]   = rd_data_reg[s].bone;
            end
            else
            begin
                out_weight[s] = '0;
                out_bone[s]   = '0;
            end
            rep_bone[s]  = (!beyond_reg && (out_weight[s] != '0)) ? out_bone[s] : '0;
            rep_share[s] = beyond_reg ? '0 : share_reg[s];
        end
    end

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_addr_reg == AW'(MAX_VERTICES - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (request.command == CMD_ADD)
                    begin
                        state_next = add_ok ? ST_ADD : ST_IDLE;
                    end
                    else
                    begin
                        state_next = beyond_in ? ST_OUT : ST_SUM;
                    end
                end
            end
            ST_ADD:
            begin
                state_next = ST_IDLE;
            end
            ST_SUM:
            begin
                if (sum_last)
                begin
                    state_next = (sum_next != '0) ? ST_DIV : ST_OUT;
                end
            end
            ST_DIV:
            begin
                if (div_done && out_last)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: outputs
    // ------------------------------------------------------------------
    always_comb
    begin
        busy        = 1'b1;
        mem_wr_en   = 1'b0;
        mem_wr_addr = addr_reg;
        mem_wr_data = add_entry;
        div_start   = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = clr_addr_reg;
                mem_wr_data = '0;
            end
            ST_IDLE:
            begin
                busy = 1'b0;
            end
            ST_ADD:
            begin
                mem_wr_en = add_hit;
            end
            ST_SUM:
            begin
                // clear the entry once it has been read
                mem_wr_en   = sum_last;
                mem_wr_data = '0;
            end
            ST_DIV:
            begin
                div_start = div_pend_reg;
            end
            ST_OUT:
            begin
                busy = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Store: one write port, one registered read port
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (mem_wr_en)
        begin
            store_mem[mem_wr_addr] <= mem_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_data_reg <= store_mem[AW'(request.vertex_id)];
        end
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            clr_addr_reg     <= '0;
            slot_idx_reg     <= '0;
            out_idx_reg      <= '0;
            div_pend_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
            vertex_count_reg <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= state_reg == ST_OUT;

            if (cfg_write && (paddr[PADDR_W-1:2] == REG_VERTEX_COUNT))
            begin
                vertex_count_reg <= pwdata[COUNT_W-1:0];
            end

            // advance the clearing sweep
            if (state_reg == ST_CLEAR)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end

            if (accept)
            begin
                slot_idx_reg <= '0;
            end
            else if ((state_reg == ST_SUM) && !sum_last)
            begin
                slot_idx_reg <= slot_idx_reg + 1'b1;
            end

            // step the divider over the reported slots
            if ((state_reg == ST_SUM) && sum_last)
            begin
                out_idx_reg  <= '0;
                div_pend_reg <= 1'b1;
            end
            else if (state_reg == ST_DIV)
            begin
                if (div_pend_reg)
                begin
                    div_pend_reg <= 1'b0;
                end
                if (div_done && !out_last)
                begin
                    out_idx_reg  <= out_idx_reg + 1'b1;
                    div_pend_reg <= 1'b1;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            vertex_reg <= request.vertex_id;
            addr_reg   <= AW'(request.vertex_id);
            bone_reg   <= request.bone_index;
            weight_reg <= weight_sat;
            beyond_reg <= beyond_in;
            sum_reg    <= '0;
            for (int s = 0; s < OUT_SLOTS; s++)
            begin
                share_reg[s] <= '0;
            end
        end
        else if (state_reg == ST_SUM)
        begin
            sum_reg <= sum_next;
        end
        else if ((state_reg == ST_DIV) && div_done)
        begin
            share_reg[out_idx_reg] <= div_quot;
        end

        // build the result
        if (state_reg == ST_OUT)
        begin
            result_reg.vertex_out <= vertex_reg;
            result_reg.bone_a     <= rep_bone[0];
            result_reg.bone_b     <= rep_bone[1];
            result_reg.bone_c     <= rep_bone[2];
            result_reg.bone_d     <= rep_bone[3];
            result_reg.share_a    <= rep_share[0];
            result_reg.share_b    <= rep_share[1];
            result_reg.share_c    <= rep_share[2];
            result_reg.share_d    <= rep_share[3];
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV) && !div_pend_reg)
        else $error("divider finished outside the divide phase");

    a_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !busy)
        else $error("result strobe while the block is still busy");

    a_read_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (request.command == CMD_READ)) |=> busy && !result_valid)
        else $error("accepted read did not start a sequence");

    a_clear_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !accept && mem_wr_en)
        else $error("request accepted during the clearing sweep");

endmodule
`default_nettype wire

>>> hw/rtl/swt4n_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// swt4n_div: bit-serial share divider
// Computes floor(num * 2^16 / den) for num <= den, one quotient bit per
// cycle by restoring division; done pulses with the quotient ready.
// ----------------------------------------------------------------------------
module swt4n_div #(
    parameter int DEN_W = 19
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [swt4n_pkg::WEIGHT_W-1:0] num,
    input  wire logic [DEN_W-1:0]              den,
    output logic                               done,
    output logic [swt4n_pkg::WEIGHT_W-1:0]     quot
);
    import swt4n_pkg::*;

    localparam int REM_W  = DEN_W + 1;
    localparam int STEP_W = $clog2(WEIGHT_W);

    logic                run_reg;
    logic                done_reg;
    logic [STEP_W-1:0]   step_reg;
    logic [REM_W-1:0]    rem_reg;
    logic [REM_W-1:0]    rem_next;
    logic [REM_W-1:0]    rem_trial;
    logic [DEN_W-1:0]    den_reg;
    logic [WEIGHT_W-1:0] quot_reg;
    logic                fits;
    logic                last_step;

    // Trial subtract, keep the remainder, shift for the next bit
    always_comb
    begin
        fits      = rem_reg >= {1'b0, den_reg};
        rem_trial = fits ? (rem_reg - {1'b0, den_reg}) : rem_reg;
        rem_next  = {rem_trial[REM_W-2:0], 1'b0};
        last_step = step_reg == STEP_W'(WEIGHT_W - 1);
    end

    // Control: run flag, step count, done pulse
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= run_reg && last_step;
            if (start)
            begin
                run_reg  <= 1'b1;
                step_reg <= '0;
            end
            else if (run_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (last_step)
                begin
                    run_reg <= 1'b0;
                end
            end
        end
    end

    // Datapath: load operands, then advance one quotient bit per cycle
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= REM_W'(num);
            den_reg  <= den;
            quot_reg <= '0;
        end
        else if (run_reg)
        begin
            rem_reg  <= rem_next;
            quot_reg <= {quot_reg[WEIGHT_W-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule
`default_nettype wire

>>> tb/sv/swt4n_skin_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// swt4n_skin_checker: influence store predictor and result checker
// Watches the APB port and both request and result channels of the skin weight
// normalizer. Keeps its own copy of the per-vertex influence slots and the
// vertex_count register, predicts each read's normalized skin at the moment the
// request is accepted, and compares every strobed result field by field.
// ----------------------------------------------------------------------------
module swt4n_skin_checker (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [swt4n_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [swt4n_pkg::DATA_W-1:0]   pwdata,
    input  wire logic                           pready,
    input  wire logic                           start,
    input  wire logic                           busy,
    input  wire swt4n_pkg::in_req_t             request,
    input  wire logic                           result_valid,
    input  wire swt4n_pkg::result_t             result,
    output int                                  mismatches,
    output int                                  pending,
    output int                                  skins_checked
);
    import swt4n_pkg::*;

    localparam int STORE_DEPTH = DEF_MAX_VERTICES;
    localparam int SLOT_COUNT  = DEF_SLOTS;

    slot_t              influence [STORE_DEPTH][SLOT_COUNT];
    logic [COUNT_W-1:0] vertex_limit;
    result_t            expected_skins [$];
    int                 errs    = 0;
    int                 checked = 0;

    // Replace the first weakest slot when the saturated weight beats it strictly.
    // Vertex and bone always fit the store by width, so only vertex_count gates.
    task automatic apply_influence(input logic [VERTEX_W-1:0] vtx,
                                   input logic [BONE_W-1:0]   bone,
                                   input logic [WEIGHT_W-1:0] weight);
        logic [WEIGHT_W-1:0] clipped;
        int                  weakest;
        int                  s;
        clipped = (weight > ONE_Q16) ? ONE_Q16 : weight;
        if ({1'b0, vtx} < vertex_limit)
        begin
            weakest = 0;
            for (s = 1; s < SLOT_COUNT; s++)
                if (influence[vtx][s].weight < influence[vtx][weakest].weight)
                    weakest = s;
            if (clipped > influence[vtx][weakest].weight)
            begin
                influence[vtx][weakest].weight = clipped;
                influence[vtx][weakest].bone   = bone;
            end
        end
    endtask

    // Build the normalized skin of one vertex, then clear its entry.
    task automatic normalize_skin(input logic [VERTEX_W-1:0] vtx, output result_t skin);
        longint unsigned     total;
        longint unsigned     wt;
        logic [WEIGHT_W-1:0] share [OUT_SLOTS];
        logic [BONE_W-1:0]   bone  [OUT_SLOTS];
        int                  s;
        total = 0;
        for (s = 0; s < SLOT_COUNT; s++)
            total += influence[vtx][s].weight;
        for (s = 0; s < OUT_SLOTS; s++)
        begin
            wt       = influence[vtx][s].weight;
            share[s] = (total != 0) ? WEIGHT_W'((wt * WEIGHT_ONE) / total)
                                    : WEIGHT_W'(wt);
            bone[s]  = (wt != 0) ? influence[vtx][s].bone : '0;
        end
        skin.vertex_out = vtx;
        skin.bone_a     = bone[0];
        skin.bone_b     = bone[1];
        skin.bone_c     = bone[2];
        skin.bone_d     = bone[3];
        skin.share_a    = share[0];
        skin.share_b    = share[1];
        skin.share_c    = share[2];
        skin.share_d    = share[3];
        for (s = 0; s < SLOT_COUNT; s++)
            influence[vtx][s] = '0;
    endtask

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, actual %0d", field, want, got);
            errs++;
        end
    endtask

    always @(posedge clk)
    begin : watch
        result_t want;
        int      v;
        int      s;
        if (!rst_n)
        begin
            // Hold the predicted store at its reset contents
            for (v = 0; v < STORE_DEPTH; v++)
                for (s = 0; s < SLOT_COUNT; s++)
                    influence[v][s] = '0;
            vertex_limit = '0;
            expected_skins.delete();
        end
        else
        begin
            // Compare a strobed result with the oldest predicted skin
            if (result_valid)
            begin
                if (expected_skins.size() == 0)
                begin
                    $error("result for vertex %0d with no read outstanding",
                           result.vertex_out);
                    errs++;
                end
                else
                begin
                    want = expected_skins.pop_front();
                    check_field("vertex_out", want.vertex_out, result.vertex_out);
                    check_field("bone_a", want.bone_a, result.bone_a);
                    check_field("bone_b", want.bone_b, result.bone_b);
                    check_field("bone_c", want.bone_c, result.bone_c);
                    check_field("bone_d", want.bone_d, result.bone_d);
                    check_field("share_a", want.share_a, result.share_a);
                    check_field("share_b", want.share_b, result.share_b);
                    check_field("share_c", want.share_c, result.share_c);
                    check_field("share_d", want.share_d, result.share_d);
                    checked++;
                end
            end

            // Advance the predicted store on each accepted request
            if (start && !busy)
            begin
                if (request.command == CMD_ADD)
                    apply_influence(request.vertex_id, request.bone_index,
                                    request.weight_in);
                else
                begin
                    normalize_skin(request.vertex_id, want);
                    expected_skins = {expected_skins, want};
                end
            end

            // Track register writes; they take effect after this edge
            if (psel && penable && pwrite && pready
                && paddr[PADDR_W-1:2] == REG_VERTEX_COUNT)
                vertex_limit = pwdata[COUNT_W-1:0];
        end
        pending       <= expected_skins.size();
        mismatches    <= errs;
        skins_checked <= checked;
    end

endmodule
`default_nettype wire

>>> tb/sv/tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for the skin weight normalizer
// Drives directed corner requests, then phases of random add/read sequences
// under several vertex_count settings, with random sender gaps and drains.
// Prediction and checking live in swt4n_skin_checker.
// ----------------------------------------------------------------------------
module tb;
    import swt4n_pkg::*;

    localparam int   IDLE_LIMIT   = 20000;
    localparam int   SETTLE       = 100;
    localparam int   RANDOM_ITEMS = 950;
    localparam int   PHASE_ITEMS  = 120;
    localparam logic REG_UNUSED   = ~REG_VERTEX_COUNT;

    logic               clk     = 1'b0;
    logic               rst_n   = 1'b0;
    logic               psel    = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite  = 1'b0;
    logic [PADDR_W-1:0] paddr   = '0;
    logic [DATA_W-1:0]  pwdata  = '0;
    logic [DATA_W-1:0]  prdata;
    logic               pready;
    logic               start   = 1'b0;
    in_req_t            request = '0;
    logic               busy;
    logic               result_valid;
    result_t            result;

    int                 mismatches;
    int                 pending;
    int                 skins_checked;

    int                 idle_cycles   = 0;
    int                 adds_issued   = 0;
    int                 reads_issued  = 0;
    int                 live_items    = 0;
    int                 settings_used = 0;
    logic               no_gaps       = 1'b0;
    logic [COUNT_W-1:0] cur_count     = '0;

    skin_weight_top4_normalizer_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .start        (start),
        .request      (request),
        .busy         (busy),
        .result_valid (result_valid),
        .result       (result)
    );

    swt4n_skin_checker u_skin_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .start         (start),
        .busy          (busy),
        .request       (request),
        .result_valid  (result_valid),
        .result        (result),
        .mismatches    (mismatches),
        .pending       (pending),
        .skins_checked (skins_checked)
    );

    always #1 clk = ~clk;

    // Abort when nothing is accepted for too long
    always @(posedge clk)
    begin
        if ((start && !busy) || result_valid || (psel && penable && pwrite && pready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic apb_write(input logic reg_index, input logic [DATA_W-1:0] value);
        @(negedge clk);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = {reg_index, 2'b00};
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        if (reg_index == REG_VERTEX_COUNT)
        begin
            cur_count = value[COUNT_W-1:0];
            settings_used++;
        end
    endtask

    // Drop start and hold until every predicted skin has come back
    task automatic drain();
        @(negedge clk);
        start = 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic send_request(input logic cmd, input logic [VERTEX_W-1:0] vtx,
                                input logic [BONE_W-1:0] bone,
                                input logic [WEIGHT_W-1:0] weight);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 5);
        @(negedge clk);
        if (gap != 0)
        begin
            start = 1'b0;
            repeat (gap) @(negedge clk);
        end
        request.command    = cmd;
        request.vertex_id  = vtx;
        request.bone_index = bone;
        request.weight_in  = weight;
        start = 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        // Count every accepted request
        live_items++;
        if (cmd == CMD_READ)
        begin
            reads_issued++;
        end
        else
        begin
            adds_issued++;
        end
    endtask

    function automatic logic [WEIGHT_W-1:0] pick_weight();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return ONE_Q16;
            2:       return WEIGHT_W'($urandom_range(WEIGHT_ONE + 1, (1 << WEIGHT_W) - 1));
            3:       return WEIGHT_W'($urandom_range(1, 16));
            default: return WEIGHT_W'($urandom_range(0, WEIGHT_ONE));
        endcase
    endfunction

    initial
    begin : stimulus
        logic [VERTEX_W-1:0] pool [6];
        logic [VERTEX_W-1:0] vtx;
        int                  phase;
        int                  span;
        int                  phase_start;
        int                  phase_issued;
        int                  n;
        int                  i;

        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        // Configure during the clearing sweep; the unused index must do nothing
        apb_write(REG_VERTEX_COUNT, DEF_MAX_VERTICES);
        apb_write(REG_UNUSED, $urandom());

        // Directed: empty vertex, saturation, zero weight, tie, replacement
        send_request(CMD_READ, 12'd0, 7'd0, '0);
        send_request(CMD_ADD, 12'd0, 7'd127, 17'h1FFFF);
        send_request(CMD_ADD, 12'd0, 7'd0, 17'd0);
        send_request(CMD_ADD, 12'd0, 7'd5, 17'd1);
        send_request(CMD_ADD, 12'd0, 7'd64, ONE_Q16);
        send_request(CMD_ADD, 12'd0, 7'd1, 17'd1);
        send_request(CMD_ADD, 12'd0, 7'd2, 17'd1);
        send_request(CMD_ADD, 12'd0, 7'd3, 17'd2);
        send_request(CMD_READ, 12'd0, 7'd0, '0);
        send_request(CMD_READ, 12'd0, 7'd0, '0);
        // Directed: top vertex filled, single-slot vertex
        send_request(CMD_ADD, 12'hFFF, 7'd127, 17'd65535);
        send_request(CMD_ADD, 12'hFFF, 7'd126, 17'd12345);
        send_request(CMD_ADD, 12'hFFF, 7'd42, ONE_Q16);
        send_request(CMD_ADD, 12'hFFF, 7'd85, 17'd3);
        send_request(CMD_READ, 12'hFFF, 7'h7F, 17'h1FFFF);
        send_request(CMD_ADD, 12'hAAA, 7'h55, 17'h10001);
        send_request(CMD_READ, 12'hAAA, 7'd0, '0);
        // Directed: no vertices enabled, then only vertex 0
        drain();
        apb_write(REG_VERTEX_COUNT, 0);
        send_request(CMD_ADD, 12'd0, 7'd9, 17'd100);
        send_request(CMD_READ, 12'd0, 7'd0, '0);
        drain();
        apb_write(REG_VERTEX_COUNT, 1);
        send_request(CMD_ADD, 12'd1, 7'd7, 17'd500);
        send_request(CMD_ADD, 12'd0, 7'd7, 17'd500);
        send_request(CMD_READ, 12'd1, 7'd0, '0);
        send_request(CMD_READ, 12'd0, 7'd0, '0);

        // Random phases, each under its own vertex_count
        live_items = 0;
        phase = 0;
        while (live_items < RANDOM_ITEMS)
        begin
            drain();
            case (phase % 8)
                0:       apb_write(REG_VERTEX_COUNT, DEF_MAX_VERTICES);
                1:       apb_write(REG_VERTEX_COUNT, $urandom_range(2, 64));
                2:       apb_write(REG_VERTEX_COUNT, $urandom_range(1, DEF_MAX_VERTICES));
                3:       apb_write(REG_VERTEX_COUNT, 1);
                4:       apb_write(REG_VERTEX_COUNT, (1 << COUNT_W) - 1);
                5:       apb_write(REG_VERTEX_COUNT, $urandom_range(2, 64));
                6:       apb_write(REG_VERTEX_COUNT, $urandom_range(1, (1 << COUNT_W) - 1));
                default: apb_write(REG_VERTEX_COUNT, 0);
            endcase
            no_gaps = ($urandom_range(0, 3) == 0);

            // Pick a few hot vertices so adds pile up before each read
            span = (cur_count > DEF_MAX_VERTICES) ? DEF_MAX_VERTICES : cur_count;
            for (i = 0; i < 6; i++)
                pool[i] = (span == 0) ? VERTEX_W'($urandom())
                                      : VERTEX_W'($urandom_range(0, span - 1));
            if (span != 0)
            begin
                pool[0] = '0;
                pool[1] = VERTEX_W'(span - 1);
            end

            phase_start  = live_items;
            phase_issued = 0;
            while (live_items - phase_start < PHASE_ITEMS && phase_issued < 300
                   && live_items < RANDOM_ITEMS)
            begin
                case ($urandom_range(0, 19))
                    // Stray add anywhere, including beyond vertex_count
                    14, 15:
                    begin
                        send_request(CMD_ADD, VERTEX_W'($urandom()), BONE_W'($urandom()),
                                     WEIGHT_W'($urandom()));
                        phase_issued++;
                    end
                    16, 17:
                    begin
                        send_request(CMD_READ, VERTEX_W'($urandom()), BONE_W'($urandom()),
                                     WEIGHT_W'($urandom()));
                        phase_issued++;
                    end
                    // Hold off until every outstanding read has returned
                    18:
                        drain();
                    default:
                    begin
                        vtx = pool[$urandom_range(0, 5)];
                        n = $urandom_range(1, 8);
                        repeat (n)
                            send_request(CMD_ADD, vtx, BONE_W'($urandom()), pick_weight());
                        if ($urandom_range(0, 4) != 0)
                            send_request(CMD_READ, vtx, BONE_W'($urandom()),
                                         WEIGHT_W'($urandom()));
                        phase_issued += n + 1;
                    end
                endcase
            end
            phase++;
        end

        drain();
        repeat (SETTLE) @(posedge clk);
        $display("Covered %0d adds and %0d reads over %0d vertex_count settings,",
                 adds_issued, reads_issued, settings_used);
        $display("with %0d normalized skins compared against the predicted store.",
                 skins_checked);
        if (mismatches == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
`default_nettype wire
